[hw/rtl/rect_line_clipper_macros.svh]
// Assertion helpers for the line clipper. Both forms use the block clock and
// asynchronous reset names of the project.
`ifndef RECT_LINE_CLIPPER_MACROS_SVH
`define RECT_LINE_CLIPPER_MACROS_SVH

`ifndef SYNTHESIS
`define RLC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define RLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RLC_ASSERT_IMPL(lbl, ante, cons, msg)
`define RLC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/rlc_pkg.sv]
`timescale 1ns / 1ps

package rlc_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // Slope magnitude width is capped at 62 bits; the slope saturates at all ones of its width.
  localparam int SLOPE_CAP_BITS = 62;

  localparam int MOVE_LIMIT = 4;
  localparam int MOVE_BITS  = 3;

  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIN_X_MIN = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIN_Y_MIN = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIN_X_MAX = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIN_Y_MAX = 3'd3;

  localparam int WIN_X_MIN_RST = 0;
  localparam int WIN_Y_MIN_RST = 0;
  localparam int WIN_X_MAX_RST = 639;
  localparam int WIN_Y_MAX_RST = 479;

  localparam logic [3:0] OC_LEFT   = 4'h1;
  localparam logic [3:0] OC_RIGHT  = 4'h2;
  localparam logic [3:0] OC_BOTTOM = 4'h4;
  localparam logic [3:0] OC_TOP    = 4'h8;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } op_e;

  typedef struct packed {
    logic load;
    logic eval_step;
    logic latch_out;
    logic slope_start;
    logic slope_latch;
    logic step_start;
    logic step_apply;
    logic edge_only;
  } cmd_t;

  typedef struct packed {
    logic finish;
    logic x_ne;
    logic code_lr;
    logic unit_done;
  } sts_t;

endpackage

[hw/rtl/rect_line_clipper.sv]
// One segment at a time: the next beat is taken at the edge after the result beat leaves.
// With no clip move the segment goes from the evaluate state straight to the output state.
// Each move takes at most a slope division and a step multiply or divide on one shared
// bit-serial unit, at most four moves.
// Reset (rst_ni low, asynchronous) loads the default window and empties the block.
`timescale 1ns / 1ps
`include "rect_line_clipper_macros.svh"

module rect_line_clipper #(
  parameter int COORD_BITS = rlc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rlc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // clip_x0, clip_y0, clip_x1, clip_y1
  output logic [((4*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // visible
  output logic                              m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rlc_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [COORD_BITS-1:0]             cfg_data_i
);

  localparam int C  = COORD_BITS;
  localparam int DW = ((4*COORD_BITS+7)/8)*8;

  rlc_pkg::cmd_t cmd;
  rlc_pkg::sts_t sts;
  logic [C-1:0]  cx0, cy0, cx1, cy1;

  assign cfg_ready_o = 1'b1;

  rlc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rlc_dpath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_idx_i  (cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .start_x_i  (s_axis_tdata[C-1:0]),
    .start_y_i  (s_axis_tdata[2*C-1:C]),
    .end_x_i    (s_axis_tdata[3*C-1:2*C]),
    .end_y_i    (s_axis_tdata[4*C-1:3*C]),
    .visible_o  (m_axis_tuser),
    .clip_x0_o  (cx0),
    .clip_y0_o  (cy0),
    .clip_x1_o  (cx1),
    .clip_y1_o  (cy1)
  );

  assign m_axis_tdata = DW'({cy1, cx1, cy0, cx0});

  `RLC_ASSERT_IMPL(a_reject_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "rejected segment with nonzero coordinates")
  `RLC_ASSERT_IMPL(a_one_item, s_axis_tready, !m_axis_tvalid, "input taken while a result is pending")
  `RLC_ASSERT_IMPL(a_slope_dx, cmd.slope_start, sts.x_ne, "slope division with zero dx")
  `RLC_ASSERT_NEXT(a_load_eval, cmd.load, !s_axis_tready && !m_axis_tvalid, "segment load not followed by evaluation")

endmodule

[hw/rtl/rlc_muldiv.sv]
`timescale 1ns / 1ps

// Shared iterative unit: restoring division of (a << FB) by b, or shift-add
// product (a * b) >> FB, one bit per cycle, result saturated at cap.
module rlc_muldiv #(
  parameter int AW = 34,
  parameter int FB = 16,
  parameter int SW = 50
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  rlc_pkg::op_e   op_i,
  input  logic [AW-1:0]  a_i,
  input  logic [SW-1:0]  b_i,
  input  logic [SW-1:0]  cap_i,
  output logic           done_o,
  output logic [SW-1:0]  res_o
);

  localparam int NW = AW + FB;
  localparam int PW = AW + SW;
  localparam int CW = $clog2(NW + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  rlc_pkg::op_e      op_q, op_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [NW-1:0]     num_q, num_d;
  logic [SW-1:0]     rem_q, rem_d;
  logic [PW-1:0]     acc_q, acc_d;
  logic [SW-1:0]     b_q, b_d;
  logic [SW-1:0]     cap_q, cap_d;
  logic [SW-1:0]     res_q, res_d;

  logic [SW:0]       rem_sh;
  logic              ge;
  logic [PW-FB-1:0]  prod;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    b_d    = b_q;
    cap_d  = cap_q;
    res_d  = res_q;
    rem_sh = {rem_q, num_q[NW-1]};
    ge     = rem_sh >= {1'b0, b_q};
    prod   = acc_q[PW-1:FB];
    if (start_i) begin
      busy_d = 1'b1;
      op_d   = op_i;
      cnt_d  = (op_i == rlc_pkg::OP_DIV) ? CW'(NW) : CW'(AW);
      num_d  = {a_i, {FB{1'b0}}};
      rem_d  = '0;
      acc_d  = '0;
      b_d    = b_i;
      cap_d  = cap_i;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - CW'(1);
        if (op_q == rlc_pkg::OP_DIV) begin
          rem_d = ge ? SW'(rem_sh - {1'b0, b_q}) : rem_sh[SW-1:0];
          num_d = {num_q[NW-2:0], ge};
        end else begin
          acc_d = {acc_q[PW-2:0], 1'b0} + (num_q[NW-1] ? PW'(b_q) : '0);
          num_d = {num_q[NW-2:0], 1'b0};
        end
      end else begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (op_q == rlc_pkg::OP_DIV) begin
          res_d = (num_q > NW'(cap_q)) ? cap_q : num_q[SW-1:0];
        end else begin
          res_d = (prod > (PW-FB)'(cap_q)) ? cap_q : prod[SW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= rlc_pkg::OP_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
    b_q   <= b_d;
    cap_q <= cap_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[hw/rtl/rlc_dpath.sv]
`timescale 1ns / 1ps

module rlc_dpath #(
  parameter int COORD_BITS = rlc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rlc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rlc_pkg::cmd_t                     cmd_i,
  output rlc_pkg::sts_t                     sts_o,
  input  logic                              cfg_we_i,
  input  logic [rlc_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [COORD_BITS-1:0]             cfg_data_i,
  input  logic [COORD_BITS-1:0]             start_x_i,
  input  logic [COORD_BITS-1:0]             start_y_i,
  input  logic [COORD_BITS-1:0]             end_x_i,
  input  logic [COORD_BITS-1:0]             end_y_i,
  output logic                              visible_o,
  output logic [COORD_BITS-1:0]             clip_x0_o,
  output logic [COORD_BITS-1:0]             clip_y0_o,
  output logic [COORD_BITS-1:0]             clip_x1_o,
  output logic [COORD_BITS-1:0]             clip_y1_o
);

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int P    = C + F + 1;
  localparam int AW   = P + 1;
  localparam int NW   = AW + F;
  localparam int SW   = (NW < rlc_pkg::SLOPE_CAP_BITS) ? NW : rlc_pkg::SLOPE_CAP_BITS;
  localparam int SUMW = SW + 2;

  localparam logic [SW-1:0] SLOPE_CAP = {SW{1'b1}};
  localparam logic [SW-1:0] STEP_CAP  = SW'(1) << (C + F + 1);
  localparam logic [P:0]    HALF      = (P+1)'(1) << (F - 1);

  function automatic logic signed [P-1:0] scale(input logic [C-1:0] v);
    scale = {v[C-1], v, {F{1'b0}}};
  endfunction

  function automatic logic [AW-1:0] magn(input logic signed [AW-1:0] v);
    magn = v[AW-1] ? AW'(-v) : AW'(v);
  endfunction

  function automatic logic [C-1:0] rnd(input logic signed [P-1:0] v);
    logic [P:0] t;
    t   = {v[P-1], v} + HALF;
    rnd = t[F+C-1:F];
  endfunction

  function automatic logic signed [P-1:0] clampp(input logic signed [SUMW-1:0] s);
    logic [SUMW-P:0] top;
    top = s[SUMW-1:P-1];
    if ((&top) || !(|top)) begin
      clampp = s[P-1:0];
    end else begin
      clampp = s[SUMW-1] ? {1'b1, {(P-1){1'b0}}} : {1'b0, {(P-1){1'b1}}};
    end
  endfunction

  logic [C-1:0] wxmin_q, wymin_q, wxmax_q, wymax_q;

  logic signed [P-1:0] x1_q, y1_q, x2_q, y2_q;
  logic signed [P-1:0] x1_d, y1_d, x2_d, y2_d;
  logic [3:0]          code_q, code_d;
  logic [SW-1:0]       m_mag_q, m_mag_d;
  logic                m_neg_q, m_neg_d;
  logic                vis_q;
  logic [C-1:0]        ox0_q, oy0_q, ox1_q, oy1_q;

  logic signed [P-1:0]  wx0, wy0, wx1, wy1;
  logic [3:0]           c1, c2;
  logic                 accept, share, lr, m_neg_eff, step_neg;
  logic signed [P-1:0]  edge_x, edge_y;
  logic signed [AW-1:0] dx, dy, ex, ey;
  logic                 unit_start, unit_done;
  rlc_pkg::op_e         unit_op;
  logic [AW-1:0]        unit_a;
  logic [SW-1:0]        unit_b, unit_cap, unit_res;
  logic signed [SUMW-1:0] step_s, cur_s, sum_s;
  logic signed [P-1:0]  upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wxmin_q <= C'(rlc_pkg::WIN_X_MIN_RST);
      wymin_q <= C'(rlc_pkg::WIN_Y_MIN_RST);
      wxmax_q <= C'(rlc_pkg::WIN_X_MAX_RST);
      wymax_q <= C'(rlc_pkg::WIN_Y_MAX_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rlc_pkg::REG_WIN_X_MIN: wxmin_q <= cfg_data_i;
        rlc_pkg::REG_WIN_Y_MIN: wymin_q <= cfg_data_i;
        rlc_pkg::REG_WIN_X_MAX: wxmax_q <= cfg_data_i;
        rlc_pkg::REG_WIN_Y_MAX: wymax_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    wx0 = scale(wxmin_q);
    wy0 = scale(wymin_q);
    wx1 = scale(wxmax_q);
    wy1 = scale(wymax_q);
    c1  = 4'h0;
    c2  = 4'h0;
    if (x1_q < wx0) c1 = c1 | rlc_pkg::OC_LEFT;
    if (x1_q > wx1) c1 = c1 | rlc_pkg::OC_RIGHT;
    if (y1_q < wy0) c1 = c1 | rlc_pkg::OC_BOTTOM;
    if (y1_q > wy1) c1 = c1 | rlc_pkg::OC_TOP;
    if (x2_q < wx0) c2 = c2 | rlc_pkg::OC_LEFT;
    if (x2_q > wx1) c2 = c2 | rlc_pkg::OC_RIGHT;
    if (y2_q < wy0) c2 = c2 | rlc_pkg::OC_BOTTOM;
    if (y2_q > wy1) c2 = c2 | rlc_pkg::OC_TOP;
    accept = (c1 | c2) == 4'h0;
    share  = (c1 & c2) != 4'h0;
    lr     = (code_q & (rlc_pkg::OC_LEFT | rlc_pkg::OC_RIGHT)) != 4'h0;
    edge_x = ((code_q & rlc_pkg::OC_LEFT) != 4'h0) ? wx0 : wx1;
    edge_y = ((code_q & rlc_pkg::OC_BOTTOM) != 4'h0) ? wy0 : wy1;
    dx     = AW'(x2_q) - AW'(x1_q);
    dy     = AW'(y2_q) - AW'(y1_q);
    ex     = AW'(edge_x) - AW'(x1_q);
    ey     = AW'(edge_y) - AW'(y1_q);
  end

  assign sts_o.finish    = accept | share;
  assign sts_o.x_ne      = x1_q != x2_q;
  assign sts_o.code_lr   = lr;
  assign sts_o.unit_done = unit_done;

  // A zero slope carries no sign into the step.
  assign m_neg_eff = m_neg_q & (m_mag_q != '0);

  always_comb begin
    unit_start = cmd_i.slope_start | cmd_i.step_start;
    if (cmd_i.slope_start) begin
      unit_op  = rlc_pkg::OP_DIV;
      unit_a   = magn(dy);
      unit_b   = SW'(magn(dx));
      unit_cap = SLOPE_CAP;
    end else begin
      unit_op  = lr ? rlc_pkg::OP_MUL : rlc_pkg::OP_DIV;
      unit_a   = lr ? magn(ex) : magn(ey);
      unit_b   = m_mag_q;
      unit_cap = STEP_CAP;
    end
  end

  rlc_muldiv #(
    .AW (AW),
    .FB (F),
    .SW (SW)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .op_i    (unit_op),
    .a_i     (unit_a),
    .b_i     (unit_b),
    .cap_i   (unit_cap),
    .done_o  (unit_done),
    .res_o   (unit_res)
  );

  always_comb begin
    step_neg = (lr ? ex[AW-1] : ey[AW-1]) ^ m_neg_eff;
    step_s   = step_neg ? -SUMW'(unit_res) : SUMW'(unit_res);
    cur_s    = lr ? SUMW'(y1_q) : SUMW'(x1_q);
    sum_s    = cur_s + step_s;
    upd      = clampp(sum_s);

    x1_d    = x1_q;
    y1_d    = y1_q;
    x2_d    = x2_q;
    y2_d    = y2_q;
    code_d  = code_q;
    m_mag_d = m_mag_q;
    m_neg_d = m_neg_q;
    if (cmd_i.load) begin
      x1_d = scale(start_x_i);
      y1_d = scale(start_y_i);
      x2_d = scale(end_x_i);
      y2_d = scale(end_y_i);
    end
    if (cmd_i.eval_step) begin
      if (c1 == 4'h0) begin
        x1_d   = x2_q;
        y1_d   = y2_q;
        x2_d   = x1_q;
        y2_d   = y1_q;
        code_d = c2;
      end else begin
        code_d = c1;
      end
    end
    if (cmd_i.slope_latch) begin
      m_mag_d = unit_res;
      m_neg_d = dy[AW-1] ^ dx[AW-1];
    end
    if (cmd_i.step_apply) begin
      if (lr) begin
        y1_d = upd;
        x1_d = edge_x;
      end else begin
        x1_d = upd;
        y1_d = edge_y;
      end
    end
    if (cmd_i.edge_only) begin
      y1_d = edge_y;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q    <= x1_d;
    y1_q    <= y1_d;
    x2_q    <= x2_d;
    y2_q    <= y2_d;
    code_q  <= code_d;
    m_mag_q <= m_mag_d;
    m_neg_q <= m_neg_d;
    if (cmd_i.latch_out) begin
      vis_q <= accept;
      ox0_q <= accept ? rnd(x1_q) : '0;
      oy0_q <= accept ? rnd(y1_q) : '0;
      ox1_q <= accept ? rnd(x2_q) : '0;
      oy1_q <= accept ? rnd(y2_q) : '0;
    end
  end

  assign visible_o = vis_q;
  assign clip_x0_o = ox0_q;
  assign clip_y0_o = oy0_q;
  assign clip_x1_o = ox1_q;
  assign clip_y1_o = oy1_q;

endmodule

[hw/rtl/rlc_ctrl.sv]
`timescale 1ns / 1ps

module rlc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  rlc_pkg::sts_t  sts_i,
  output rlc_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_EVAL    = 3'd1;
  localparam logic [2:0] ST_SLOPE   = 3'd2;
  localparam logic [2:0] ST_SLOPE_W = 3'd3;
  localparam logic [2:0] ST_STEP    = 3'd4;
  localparam logic [2:0] ST_STEP_W  = 3'd5;
  localparam logic [2:0] ST_OUT     = 3'd6;

  logic [2:0]                    state_q, state_d;
  logic [rlc_pkg::MOVE_BITS-1:0] moves_q, moves_d;

  always_comb begin
    state_d     = state_q;
    moves_d     = moves_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          moves_d    = '0;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts_i.finish ||
            moves_q == rlc_pkg::MOVE_BITS'(rlc_pkg::MOVE_LIMIT)) begin
          cmd_o.latch_out = 1'b1;
          state_d         = ST_OUT;
        end else begin
          cmd_o.eval_step = 1'b1;
          moves_d         = moves_q + rlc_pkg::MOVE_BITS'(1);
          state_d         = ST_SLOPE;
        end
      end
      ST_SLOPE: begin
        if (sts_i.x_ne) begin
          cmd_o.slope_start = 1'b1;
          state_d           = ST_SLOPE_W;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_SLOPE_W: begin
        if (sts_i.unit_done) begin
          cmd_o.slope_latch = 1'b1;
          state_d           = ST_STEP;
        end
      end
      ST_STEP: begin
        // A vertical segment on a bottom or top clip keeps its x.
        if (sts_i.code_lr || sts_i.x_ne) begin
          cmd_o.step_start = 1'b1;
          state_d          = ST_STEP_W;
        end else begin
          cmd_o.edge_only = 1'b1;
          state_d         = ST_EVAL;
        end
      end
      ST_STEP_W: begin
        if (sts_i.unit_done) begin
          cmd_o.step_apply = 1'b1;
          state_d          = ST_EVAL;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      moves_q <= '0;
    end else begin
      state_q <= state_d;
      moves_q <= moves_d;
    end
  end

endmodule
